// File: hdl/s256_pkg.sv
`default_nettype none
package s256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 61;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoAw = $clog2(FifoDepth);

    typedef logic [WordW-1:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } t_item;

    localparam logic [7:0] PadMarker = 8'h80;

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word ror(input t_word v, input int unsigned s);
        ror = (v >> s) | (v << (WordW - s));
    endfunction

endpackage
`default_nettype wire

// File: hdl/s256_if.sv
`default_nettype none
interface s256_in_if (input wire logic i_clk);
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;
    modport source (output valid, data_byte, has_byte, last_item, input ready);
    modport sink   (input valid, data_byte, has_byte, last_item, output ready);
endinterface

interface s256_out_if (input wire logic i_clk);
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: hdl/s256_fifo.sv
`default_nettype none
module s256_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  s256_pkg::t_item     i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output s256_pkg::t_item     o_item,
    output logic                o_empty
);
    s256_pkg::t_item                 r_mem [s256_pkg::FifoDepth];
    logic [s256_pkg::FifoAw-1:0]     r_wr, r_rd;
    logic [s256_pkg::FifoAw:0]       r_cnt;

    assign o_full  = (r_cnt == (s256_pkg::FifoAw+1)'(s256_pkg::FifoDepth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (s256_pkg::FifoAw+1)'(i_push) - (s256_pkg::FifoAw+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end
endmodule
`default_nettype wire

// File: hdl/s256_engine.sv
`default_nettype none
module s256_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  s256_pkg::t_item  i_item,
    input  wire logic        i_empty,
    output logic             o_pop,
    s256_out_if.source       o_out
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RUN   = 6'b000010,
        S_ADD   = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    s256_pkg::t_word                 r_h [8];
    s256_pkg::t_word                 r_w [16];
    s256_pkg::t_word                 r_v [8];
    logic [s256_pkg::CountW-1:0]     r_count;
    logic [5:0]                      r_round;
    logic                            r_fin;     // finish pending after this block
    logic                            r_lenblk;  // current block carries the length
    logic                            r_padded;  // marker already sent in an earlier block
    logic [2:0]                      r_idx;
    logic                            r_ovalid;

    s256_pkg::t_word w_cur, s0, s1, big0, big1, ch, maj, t1, t2, w_new;
    logic [5:0] pos;
    logic [3:0] wsel;
    logic [1:0] bsel;

    assign pos  = r_count[5:0];
    assign wsel = pos[5:2];
    assign bsel = pos[1:0];

    always_comb begin
        s0    = s256_pkg::ror(r_w[1], 7) ^ s256_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = s256_pkg::ror(r_w[14], 17) ^ s256_pkg::ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = r_w[0];
        big1  = s256_pkg::ror(r_v[4], 6) ^ s256_pkg::ror(r_v[4], 11) ^ s256_pkg::ror(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1    = r_v[7] + big1 + ch + s256_pkg::RoundK[r_round] + w_cur;
        big0  = s256_pkg::ror(r_v[0], 2) ^ s256_pkg::ror(r_v[0], 13) ^ s256_pkg::ror(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2    = big0 + maj;
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_h[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == 3'd7);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_item.has_byte && pos == 6'd63) n_state = S_RUN;
                    else if (i_item.last_item)            n_state = S_PAD;
                end
            end
            S_RUN:  if (r_round == 6'd63) n_state = S_ADD;
            S_ADD: begin
                if (r_lenblk)              n_state = S_EMIT;
                else if (r_fin && r_padded) n_state = S_LEN;
                else if (r_fin)            n_state = S_PAD;
                else                       n_state = S_IDLE;
            end
            S_PAD:  n_state = (pos >= 6'd56) ? S_RUN : S_LEN;
            S_LEN:  n_state = S_RUN;
            S_EMIT: if (o_out.ready && r_idx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_round  <= '0;
            r_fin    <= 1'b0;
            r_lenblk <= 1'b0;
            r_padded <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++)  r_h[i] <= s256_pkg::InitHash[i];
            for (int i = 0; i < 16; i++) r_w[i] <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_fin <= i_item.last_item;
                        if (i_item.has_byte) begin
                            r_w[wsel][8*(3-bsel) +: 8] <= i_item.data_byte;
                            r_count <= r_count + 1'b1;
                        end
                        if (i_item.has_byte && pos == 6'd63) begin
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            r_round <= '0;
                        end
                    end
                end
                S_RUN: begin
                    // The block array slides so the current word is always in slot 0
                    // and the word sixteen rounds ahead enters at slot 15.
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_round <= r_round + 1'b1;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++)  r_h[i] <= r_h[i] + r_v[i];
                    for (int i = 0; i < 16; i++) r_w[i] <= '0;
                    if (r_lenblk) begin
                        r_ovalid <= 1'b1;
                        r_idx    <= '0;
                    end
                end
                S_PAD: begin
                    r_w[wsel][8*(3-bsel) +: 8] <= s256_pkg::PadMarker;
                    // Marker set; a full length block follows if no room remains.
                    if (pos >= 6'd56) begin
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_round <= '0;
                        r_lenblk <= 1'b0;
                        r_padded <= 1'b1;
                        r_fin <= 1'b1;
                    end
                end
                S_LEN: begin
                    r_w[14] <= r_count[60:29];
                    r_w[15] <= {r_count[28:0], 3'b000};
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_round  <= '0;
                    r_lenblk <= 1'b1;
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_lenblk <= 1'b0;
                            r_fin    <= 1'b0;
                            r_padded <= 1'b0;
                            r_count  <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= s256_pkg::InitHash[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/sha256_byte_stream_digest_core.sv
`default_nettype none
// Channel  Role    Payload
// i_in     sink    data_byte[7:0], has_byte, last_item
// o_out    source  digest_word[31:0], word_index[2:0], last_word
//
// A byte that fills a block starts a compression (a load, 64 rounds in the
// single round unit and a fold); other bytes are only stored in the back end.
// A last item adds pad, length load and one or two compressions, then eight
// output transactions. A four-entry queue lets the input run ahead of the
// round unit. Reset is synchronous, active low, and sets the initial hash.
module sha256_byte_stream_digest_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    s256_in_if.sink     i_in,
    s256_out_if.source  o_out
);
    s256_pkg::t_item w_in_item, w_q_item;
    logic w_full, w_empty, w_pop;

    assign w_in_item = '{data_byte: i_in.data_byte, has_byte: i_in.has_byte,
                         last_item: i_in.last_item};
    assign i_in.ready = !w_full;

    s256_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_in.valid && !w_full), .i_item(w_in_item), .o_full(w_full),
        .i_pop(w_pop), .o_item(w_q_item), .o_empty(w_empty)
    );

    s256_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(w_q_item), .i_empty(w_empty), .o_pop(w_pop), .o_out(o_out)
    );
endmodule
`default_nettype wire

// File: hdl/s256_checker.sv
`default_nettype none
module s256_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word mismatch");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_ready && !last_word) |=> (out_valid &&
         word_index == $past(word_index) + 3'd1))
        else $error("word index skipped");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
        else $error("output dropped");
endmodule

bind sha256_byte_stream_digest_core s256_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(o_out.valid),
    .out_ready(o_out.ready), .word_index(o_out.word_index),
    .last_word(o_out.last_word)
);
`default_nettype wire

// File: verif/sha256_byte_stream_digest_core_tb.sv
`default_nettype none
module sha256_byte_stream_digest_core_tb;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_out;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
        logic       check_word0;
        logic [31:0] word0;
    } t_vector;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    s256_in_if  in_ch  (i_clk);
    s256_out_if out_ch (i_clk);

    sha256_byte_stream_digest_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    s256_pkg::t_word hv [8];
    s256_pkg::t_word blk [16];
    logic [60:0] byte_cnt;

    t_digest_out digest_q [$];
    int          errors;
    int          words_seen;
    int          msgs_done;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          pinned_word0;
    logic [31:0] pinned_value;

    function automatic s256_pkg::t_word rotr(s256_pkg::t_word v, int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic clear_msg();
        for (int i = 0; i < 8; i++) hv[i] = s256_pkg::InitHash[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        byte_cnt = '0;
    endtask

    task automatic compress();
        s256_pkg::t_word v [8];
        s256_pkg::t_word w, w15, w2, s0, s1, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hv[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w = blk[r];
            end else begin
                w15 = blk[(r - 15) & 15];
                w2 = blk[(r - 2) & 15];
                s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
                s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
                w = blk[r & 15] + s0 + blk[(r - 7) & 15] + s1;
                blk[r & 15] = w;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + s256_pkg::RoundK[r] + w;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] += v[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
    endtask

    task automatic insert_byte(logic [7:0] b, int pos);
        blk[(pos >> 2) & 15] |= s256_pkg::t_word'(b) << (24 - 8 * (pos & 3));
    endtask

    task automatic predict_digest(logic [7:0] b, logic has, logic last);
        int pos;
        logic [63:0] bits;
        t_digest_out d;
        if (has) begin
            pos = int'(byte_cnt[5:0]);
            insert_byte(b, pos);
            byte_cnt = byte_cnt + 1'b1;
            if (pos == 63) compress();
        end
        if (last) begin
            pos = int'(byte_cnt[5:0]);
            bits = {byte_cnt, 3'b000};
            insert_byte(s256_pkg::PadMarker, pos);
            if (pos >= 56) compress();
            blk[14] = bits[63:32];
            blk[15] = bits[31:0];
            compress();
            for (int i = 0; i < 8; i++) begin
                d.digest_word = hv[i];
                d.word_index = 3'(i);
                d.last_word = (i == 7);
                digest_q.push_back(d);
            end
            clear_msg();
            msgs_done++;
        end
    endtask

    // Valid stays high after a transaction so the next one can follow at once;
    // it drops only while the sender idles or through release_input.
    task automatic send_item(logic [7:0] b, logic has, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte <= has;
        in_ch.last_item <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_digest(b, has, last);
        @(negedge i_clk);
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_message(int len, int tail_mode);
        // tail_mode 0: last flag rides on the final byte; 1: separate end item.
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (tail_mode == 0) && (i == len - 1));
        end
        if (tail_mode != 0 || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver with random back-pressure; checks each transaction in order.
    always @(posedge i_clk) begin
        t_digest_out got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.digest_word, out_ch.word_index, out_ch.last_word};
            words_seen++;
            if (digest_q.size() == 0) begin
                $error("unexpected digest word %h", got.digest_word);
                errors++;
            end else begin
                want = digest_q.pop_front();
                if (pinned_word0 > 0 && got.word_index == 0) begin
                    pinned_word0--;
                    if (got.digest_word !== pinned_value) begin
                        $error("digest_word (known) exp %h got %h",
                            pinned_value, got.digest_word);
                        errors++;
                    end
                end
                if (got.digest_word !== want.digest_word) begin
                    $error("digest_word exp %h got %h", want.digest_word, got.digest_word);
                    errors++;
                end
                if (got.word_index !== want.word_index) begin
                    $error("word_index exp %0d got %0d", want.word_index, got.word_index);
                    errors++;
                end
                if (got.last_word !== want.last_word) begin
                    $error("last_word exp %b got %b", want.last_word, got.last_word);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_vector vecs [$];
        t_vector v;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.last_item = 1'b0;
        out_ch.ready = 1'b0;
        errors = 0;
        words_seen = 0;
        msgs_done = 0;
        pinned_word0 = 0;
        send_idle_pct = 26;
        recv_idle_pct = 79;
        clear_msg();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: empty message and "abc" have well-known first words.
        vecs.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 32'h0});        // idle item
        vecs.push_back('{8'hff, 1'b0, 1'b1, 1'b1, 32'he3b0c442}); // empty message
        vecs.push_back('{8'h61, 1'b1, 1'b0, 1'b0, 32'h0});
        vecs.push_back('{8'h62, 1'b1, 1'b0, 1'b0, 32'h0});
        vecs.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf}); // "abc"
        vecs.push_back('{8'h00, 1'b1, 1'b0, 1'b0, 32'h0});
        vecs.push_back('{8'hff, 1'b0, 1'b0, 1'b0, 32'h0});        // idle mid-message
        vecs.push_back('{8'hff, 1'b1, 1'b0, 1'b0, 32'h0});
        vecs.push_back('{8'h5a, 1'b0, 1'b1, 1'b0, 32'h0});        // end without a byte
        vecs.push_back('{8'h00, 1'b1, 1'b1, 1'b0, 32'h0});        // one-byte message
        foreach (vecs[i]) begin
            v = vecs[i];
            if (v.check_word0) begin
                pinned_word0++;
                pinned_value = v.word0;
            end
            send_item(v.data_byte, v.has_byte, v.last_item);
            if (v.check_word0) begin
                release_input();
                wait (digest_q.size() == 0);
                @(negedge i_clk);
            end
        end

        // Padding boundaries: 55, 56, 63 and 64 bytes.
        send_message(55, 0);
        send_message(56, 1);
        // Hold off until every digest is out.
        release_input();
        wait (digest_q.size() == 0);
        @(negedge i_clk);
        send_message(63, 0);
        send_message(64, 1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 26 : 0;
            for (int m = 0; m < 3; m++)
                send_message(($urandom_range(3) == 0) ? $urandom_range(70)
                                                      : $urandom_range(8),
                             $urandom_range(1));
        end

        release_input();
        wait (digest_q.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Hashed %0d messages (empty, padding edges, multi-block, random)",
            msgs_done);
        $display("checked %0d digest words under mixed back-pressure", words_seen);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sha256_byte_stream_digest_core.f
hdl/s256_pkg.sv
hdl/s256_if.sv
hdl/s256_fifo.sv
hdl/s256_engine.sv
hdl/sha256_byte_stream_digest_core.sv
hdl/s256_checker.sv
verif/sha256_byte_stream_digest_core_tb.sv
